>>> src/tpi_pkg.sv
// Shared constants for the triangle / plane crossing block.
`timescale 1ns / 1ps
`default_nettype none
package tpi_pkg;

	// Default vertex coordinate width (signed Q16.16).
	localparam int COORD_WIDTH_DEF = 32;

	// Configuration port geometry: 64-bit data, registers on 8-byte steps.
	localparam int APB_ADDR_W = 6;
	localparam int APB_DATA_W = 64;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_NORMAL_X = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_Y = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_NORMAL_Z = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_OFFSET   = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LINE_X   = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_LINE_Y   = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_LINE_Z   = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_MIN_DEN  = 3'd7;

	localparam logic [30:0] MIN_DEN_RESET = 31'd1;

endpackage
`default_nettype wire

>>> src/tpi_tri_if.sv
// Triangle input channel: valid/ready plus three vertices and the prior count.
`timescale 1ns / 1ps
`default_nettype none
interface tpi_tri_if #(
	parameter int COORD_WIDTH = tpi_pkg::COORD_WIDTH_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] ax;
	logic signed [COORD_WIDTH-1:0] ay;
	logic signed [COORD_WIDTH-1:0] az;
	logic signed [COORD_WIDTH-1:0] bx;
	logic signed [COORD_WIDTH-1:0] by_coord;
	logic signed [COORD_WIDTH-1:0] bz;
	logic signed [COORD_WIDTH-1:0] cx;
	logic signed [COORD_WIDTH-1:0] cy;
	logic signed [COORD_WIDTH-1:0] cz;
	logic [1:0]                    prior_count;

	modport source (
		output valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, prior_count,
		input  ready
	);
	modport sink (
		input  valid, ax, ay, az, bx, by_coord, bz, cx, cy, cz, prior_count,
		output ready
	);
endinterface
`default_nettype wire

>>> src/tpi_pt_if.sv
// Crossing point output channel: valid/ready plus point, projection and last flag.
`timescale 1ns / 1ps
`default_nettype none
interface tpi_pt_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] point_x;
	logic signed [31:0] point_y;
	logic signed [47:0] projection;
	logic               last;

	modport source (
		output valid, point_x, point_y, projection, last,
		input  ready
	);
	modport sink (
		input  valid, point_x, point_y, projection, last,
		output ready
	);
endinterface
`default_nettype wire

>>> src/triangle_plane_intersection.sv
// Top level of the triangle / plane crossing block.
// Each accepted triangle has its three vertex distances to the configured plane
// computed, its edges AB, BC and (depending on the running count) CA tested, and
// the crossing points found by a bit-per-stage multiply-divide pipeline of
// COORD_WIDTH stages. A new triangle can be accepted in every cycle while the
// result serializer can take it; a triangle with several crossings holds the
// serializer until each has been handed to the single output channel, which thus
// sets the sustained rate. Registers sit at byte address 8*i on the 64-bit
// configuration port and must only be written while the block holds no triangle.
`timescale 1ns / 1ps
`default_nettype none
module triangle_plane_intersection #(
	parameter int COORD_WIDTH = tpi_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	tpi_tri_if.sink                              triangle,
	tpi_pt_if.source                             crossing,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [tpi_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [tpi_pkg::APB_DATA_W-1:0]  pwdata,
	output logic [tpi_pkg::APB_DATA_W-1:0]       prdata,
	output logic                                 pready
);
	localparam int W  = COORD_WIDTH;
	localparam int PW = W + 32;
	localparam int SW = W + 34;
	localparam int EW = ((W + 18 > 48) ? W + 18 : 48) + 1;
	localparam int DW = EW + 1;
	localparam int QW = (W + 34 > 64) ? W + 34 : 64;
	localparam int NS = 6 + W;

	// ---------------- configuration registers ----------------
	logic signed [31:0] normal_q [3];
	logic signed [47:0] offset_q;
	logic signed [31:0] line_q [3];
	logic [30:0]        min_q;
	logic               cfg_wr;
	logic [tpi_pkg::REG_IDX_W-1:0] cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[tpi_pkg::APB_ADDR_W-1:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_q <= '{default: '0};
			line_q   <= '{default: '0};
			offset_q <= '0;
			min_q    <= tpi_pkg::MIN_DEN_RESET;
		end else if (cfg_wr) begin
			case (cfg_idx)
				tpi_pkg::REG_NORMAL_X: normal_q[0] <= pwdata[31:0];
				tpi_pkg::REG_NORMAL_Y: normal_q[1] <= pwdata[31:0];
				tpi_pkg::REG_NORMAL_Z: normal_q[2] <= pwdata[31:0];
				tpi_pkg::REG_OFFSET:   offset_q    <= pwdata[47:0];
				tpi_pkg::REG_LINE_X:   line_q[0]   <= pwdata[31:0];
				tpi_pkg::REG_LINE_Y:   line_q[1]   <= pwdata[31:0];
				tpi_pkg::REG_LINE_Z:   line_q[2]   <= pwdata[31:0];
				tpi_pkg::REG_MIN_DEN:  min_q       <= pwdata[30:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			tpi_pkg::REG_NORMAL_X: prdata = {32'b0, normal_q[0]};
			tpi_pkg::REG_NORMAL_Y: prdata = {32'b0, normal_q[1]};
			tpi_pkg::REG_NORMAL_Z: prdata = {32'b0, normal_q[2]};
			tpi_pkg::REG_OFFSET:   prdata = {16'b0, offset_q};
			tpi_pkg::REG_LINE_X:   prdata = {32'b0, line_q[0]};
			tpi_pkg::REG_LINE_Y:   prdata = {32'b0, line_q[1]};
			tpi_pkg::REG_LINE_Z:   prdata = {32'b0, line_q[2]};
			tpi_pkg::REG_MIN_DEN:  prdata = {33'b0, min_q};
			default:               prdata = '0;
		endcase
	end

	// ---------------- main pipeline ----------------
	// The whole front pipeline advances together whenever the serializer can take
	// the triangle in its last stage.
	logic          en_main;
	logic [NS-1:0] vld_s;

	assign triangle.ready = en_main;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en_main) begin
			vld_s <= {vld_s[NS-2:0], triangle.valid};
		end
	end

	logic signed [W-1:0] vin    [3][3];
	logic signed [W-1:0] vtx_s1 [3][3];
	logic signed [W-1:0] vtx_s2 [3][3];
	logic signed [W-1:0] vtx_s3 [3][3];
	logic signed [W-1:0] vtx_s4 [3][3];
	logic signed [W-1:0] vtx_s5 [3][3];
	logic signed [W-1:0] vtx_s6 [3][3];
	logic [1:0]          prior_s1, prior_s2, prior_s3, prior_s4, prior_s5;

	assign vin[0][0] = triangle.ax;
	assign vin[0][1] = triangle.ay;
	assign vin[0][2] = triangle.az;
	assign vin[1][0] = triangle.bx;
	assign vin[1][1] = triangle.by_coord;
	assign vin[1][2] = triangle.bz;
	assign vin[2][0] = triangle.cx;
	assign vin[2][1] = triangle.cy;
	assign vin[2][2] = triangle.cz;

	// Stages 1 and 2: vertex coordinates times the plane normal.
	logic signed [PW-1:0] dprod_s2 [3][3];

	for (genvar v = 0; v < 3; v++) begin : g_dv
		for (genvar k = 0; k < 3; k++) begin : g_dk
			tpi_smul #(.AW(W)) u_dmul (
				.clk (clk),
				.en1 (en_main),
				.en2 (en_main),
				.a   (vin[v][k]),
				.b   (normal_q[k]),
				.p   (dprod_s2[v][k])
			);
		end
	end

	logic signed [SW-1:0] vsum_s3 [3];
	logic signed [EW-1:0] dist_s4 [3];

	// Stages 5 and 6: edge tests and the operands of the interpolation.
	logic                  cross_s5 [3];
	logic signed [DW-1:0]  dv_s5    [3];
	logic signed [EW-1:0]  ep_s5    [3];
	logic signed [W:0]     d_s5     [3][3];

	logic [DW-1:0]         adv_c    [3];
	logic [DW-1:0]         aep_c    [3];
	logic signed [DW-1:0]  epx_c    [3];
	logic [2:0]            pass_c;
	logic [W:0]            dmag_c   [3][3];
	logic [2:0]            cnt_c;
	logic [2:0]            use_c;

	logic [DW-1:0]         adv_s6   [3];
	logic [DW-1:0]         aep_s6   [3];
	logic [W-1:0]          md_s6    [3][3];
	logic                  neg_s6   [3][3];
	logic [2:0]            use_s6;

	always_comb begin
		for (int e = 0; e < 3; e++) begin
			adv_c[e] = dv_s5[e][DW-1] ? DW'(-dv_s5[e]) : DW'(dv_s5[e]);
			epx_c[e] = DW'(ep_s5[e]);
			aep_c[e] = epx_c[e][DW-1] ? DW'(-epx_c[e]) : DW'(epx_c[e]);
			pass_c[e] = cross_s5[e] && (adv_c[e] > DW'({min_q, 16'b0}));
			for (int k = 0; k < 3; k++) begin
				dmag_c[e][k] = d_s5[e][k][W] ? (W+1)'(-d_s5[e][k]) : (W+1)'(d_s5[e][k]);
			end
		end
		// Edge CA only counts when the running count is odd-and-one-or-three.
		cnt_c = 3'(prior_s5) + 3'(pass_c[0]) + 3'(pass_c[1]);
		use_c = {pass_c[2] && (cnt_c == 3'd1 || cnt_c == 3'd3), pass_c[1], pass_c[0]};
	end

	always_ff @(posedge clk) begin
		if (en_main) begin
			vtx_s1   <= vin;
			vtx_s2   <= vtx_s1;
			vtx_s3   <= vtx_s2;
			vtx_s4   <= vtx_s3;
			vtx_s5   <= vtx_s4;
			vtx_s6   <= vtx_s5;
			prior_s1 <= triangle.prior_count;
			prior_s2 <= prior_s1;
			prior_s3 <= prior_s2;
			prior_s4 <= prior_s3;
			prior_s5 <= prior_s4;
			for (int v = 0; v < 3; v++) begin
				vsum_s3[v] <= SW'(dprod_s2[v][0]) + SW'(dprod_s2[v][1]) +
					SW'(dprod_s2[v][2]);
				dist_s4[v] <= EW'(vsum_s3[v] >>> 16) - EW'(offset_q);
			end
			for (int e = 0; e < 3; e++) begin
				// Edge e runs from vertex e to the next vertex, wrapping C back to A.
				cross_s5[e] <= (dist_s4[e] == '0) || (dist_s4[(e == 2) ? 0 : e + 1] == '0) ||
					(dist_s4[e][EW-1] != dist_s4[(e == 2) ? 0 : e + 1][EW-1]);
				dv_s5[e] <= DW'(dist_s4[(e == 2) ? 0 : e + 1]) - DW'(dist_s4[e]);
				ep_s5[e] <= dist_s4[e];
				for (int k = 0; k < 3; k++) begin
					d_s5[e][k] <= (W+1)'(vtx_s4[(e == 2) ? 0 : e + 1][k]) -
						(W+1)'(vtx_s4[e][k]);
					md_s6[e][k]  <= dmag_c[e][k][W-1:0];
					neg_s6[e][k] <= d_s5[e][k][W];
				end
				adv_s6[e] <= adv_c[e];
				aep_s6[e] <= aep_c[e];
			end
			use_s6 <= use_c;
		end
	end

	// Interpolation: three lanes per edge, one per coordinate.
	logic signed [W-1:0] lane_pt [3][3];
	logic [2:0]          use_div_s [W];

	for (genvar e = 0; e < 3; e++) begin : g_le
		for (genvar k = 0; k < 3; k++) begin : g_lk
			tpi_div_lane #(.W(W), .DW(DW)) u_lane (
				.clk (clk),
				.en  (en_main),
				.a   (aep_s6[e]),
				.c   (adv_s6[e]),
				.md  (md_s6[e][k]),
				.p   (vtx_s6[e][k]),
				.neg (neg_s6[e][k]),
				.pt  (lane_pt[e][k])
			);
		end
	end

	always_ff @(posedge clk) begin
		if (en_main) begin
			use_div_s[0] <= use_s6;
			for (int i = 1; i < W; i++) begin
				use_div_s[i] <= use_div_s[i-1];
			end
		end
	end

	// ---------------- result serializer ----------------
	logic [2:0]          ser_mask_q;
	logic signed [W-1:0] ser_pt_q [3][3];
	logic [1:0]          sel_idx;
	logic [2:0]          ser_rest;
	logic                ser_has;
	logic                ser_final;
	logic                ser_en;
	logic                e_j0, e_j1, e_j2;
	logic signed [W-1:0] sel_pt [3];

	always_comb begin
		sel_idx = 2'd2;
		if (ser_mask_q[0]) begin
			sel_idx = 2'd0;
		end else if (ser_mask_q[1]) begin
			sel_idx = 2'd1;
		end
		ser_rest          = ser_mask_q;
		ser_rest[sel_idx] = 1'b0;
		ser_has           = |ser_mask_q;
		ser_final         = (ser_rest == 3'b000);
		for (int k = 0; k < 3; k++) begin
			sel_pt[k] = ser_pt_q[sel_idx][k];
		end
	end

	assign ser_en  = !ser_has || (e_j0 && ser_final);
	assign en_main = ser_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ser_mask_q <= '0;
		end else if (ser_en) begin
			ser_mask_q <= vld_s[NS-1] ? use_div_s[W-1] : 3'b000;
		end else if (e_j0) begin
			ser_mask_q <= ser_rest;
		end
	end

	always_ff @(posedge clk) begin
		if (ser_en) begin
			ser_pt_q <= lane_pt;
		end
	end

	// ---------------- projection pipeline and output register ----------------
	logic               pj_vld_s1, pj_vld_s2, pj_vld_s3;
	logic signed [31:0] pj_x_s1, pj_x_s2, pj_x_s3;
	logic signed [31:0] pj_y_s1, pj_y_s2, pj_y_s3;
	logic               pj_last_s1, pj_last_s2, pj_last_s3;
	logic signed [47:0] pj_proj_s3;
	logic signed [PW-1:0] pprod_s2 [3];
	logic signed [QW-1:0] psum_c;

	assign e_j2 = !pj_vld_s3 || crossing.ready;
	assign e_j1 = !pj_vld_s2 || e_j2;
	assign e_j0 = !pj_vld_s1 || e_j1;

	for (genvar k = 0; k < 3; k++) begin : g_pk
		tpi_smul #(.AW(W)) u_pmul (
			.clk (clk),
			.en1 (e_j0),
			.en2 (e_j1),
			.a   (sel_pt[k]),
			.b   (line_q[k]),
			.p   (pprod_s2[k])
		);
	end

	assign psum_c = QW'(pprod_s2[0]) + QW'(pprod_s2[1]) + QW'(pprod_s2[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pj_vld_s1 <= 1'b0;
			pj_vld_s2 <= 1'b0;
			pj_vld_s3 <= 1'b0;
		end else begin
			if (e_j0) begin
				pj_vld_s1 <= ser_has;
			end
			if (e_j1) begin
				pj_vld_s2 <= pj_vld_s1;
			end
			if (e_j2) begin
				pj_vld_s3 <= pj_vld_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (e_j0) begin
			pj_x_s1    <= 32'(sel_pt[0]);
			pj_y_s1    <= 32'(sel_pt[1]);
			pj_last_s1 <= ser_final;
		end
		if (e_j1) begin
			pj_x_s2    <= pj_x_s1;
			pj_y_s2    <= pj_y_s1;
			pj_last_s2 <= pj_last_s1;
		end
		if (e_j2) begin
			pj_x_s3    <= pj_x_s2;
			pj_y_s3    <= pj_y_s2;
			pj_last_s3 <= pj_last_s2;
			pj_proj_s3 <= psum_c[63:16];
		end
	end

	assign crossing.valid      = pj_vld_s3;
	assign crossing.point_x    = pj_x_s3;
	assign crossing.point_y    = pj_y_s3;
	assign crossing.projection = pj_proj_s3;
	assign crossing.last       = pj_last_s3;
endmodule
`default_nettype wire

>>> src/tpi_smul.sv
// Two-stage signed multiplier that splits the coordinate operand into two halves.
`timescale 1ns / 1ps
`default_nettype none
module tpi_smul #(
	parameter int AW = tpi_pkg::COORD_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 en1,
	input  wire logic                 en2,
	input  wire logic signed [AW-1:0] a,
	input  wire logic signed [31:0]   b,
	output logic signed [AW+31:0]     p
);
	localparam int LB = AW / 2;
	localparam int PW = AW + 32;

	logic signed [LB+32:0]    lo_s1;
	logic signed [AW-LB+31:0] hi_s1;
	logic signed [PW-1:0]     p_s2;

	// The low half is unsigned, so it gets a zero sign bit before the multiply.
	always_ff @(posedge clk) begin
		if (en1) begin
			lo_s1 <= $signed({1'b0, a[LB-1:0]}) * b;
			hi_s1 <= $signed(a[AW-1:LB]) * b;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			p_s2 <= $signed({hi_s1, {LB{1'b0}}}) + PW'(lo_s1);
		end
	end

	assign p = p_s2;
endmodule
`default_nettype wire

>>> src/tpi_div_lane.sv
// Pipelined lane computing p +/- floor(a * md / c), one bit of md per stage.
`timescale 1ns / 1ps
`default_nettype none
module tpi_div_lane #(
	parameter int W  = tpi_pkg::COORD_WIDTH_DEF,
	parameter int DW = ((W + 18 > 48) ? W + 18 : 48) + 2
) (
	input  wire logic                clk,
	input  wire logic                en,
	input  wire logic [DW-1:0]       a,
	input  wire logic [DW-1:0]       c,
	input  wire logic [W-1:0]        md,
	input  wire logic signed [W-1:0] p,
	input  wire logic                neg,
	output logic signed [W-1:0]      pt
);
	// The remainder stays below c, so doubling it and adding a (a <= c) stays below 3c.
	localparam int RW = DW + 2;

	logic [RW-1:0]       rem_s [1:W];
	logic [W-1:0]        quo_s [1:W];
	logic [W-1:0]        mb_s  [1:W];
	logic [DW-1:0]       a_s   [1:W];
	logic [DW-1:0]       c_s   [1:W];
	logic signed [W-1:0] p_s   [1:W];
	logic                neg_s [1:W];

	for (genvar i = 1; i <= W; i++) begin : g_step
		logic [RW-1:0]       rem_prev;
		logic [W-1:0]        quo_prev;
		logic [W-1:0]        mb_prev;
		logic [DW-1:0]       a_prev;
		logic [DW-1:0]       c_prev;
		logic signed [W-1:0] p_prev;
		logic                neg_prev;
		logic [RW-1:0]       c1;
		logic [RW-1:0]       c2;
		logic [RW-1:0]       acc;
		logic [RW-1:0]       nrem;
		logic [1:0]          dig;

		if (i == 1) begin : g_first
			assign rem_prev = '0;
			assign quo_prev = '0;
			assign mb_prev  = md;
			assign a_prev   = a;
			assign c_prev   = c;
			assign p_prev   = p;
			assign neg_prev = neg;
		end else begin : g_next
			assign rem_prev = rem_s[i-1];
			assign quo_prev = quo_s[i-1];
			assign mb_prev  = mb_s[i-1];
			assign a_prev   = a_s[i-1];
			assign c_prev   = c_s[i-1];
			assign p_prev   = p_s[i-1];
			assign neg_prev = neg_s[i-1];
		end

		// Quotient digit is 0, 1 or 2 since the partial remainder is below 3c.
		always_comb begin
			c1  = RW'(c_prev);
			c2  = {c1[RW-2:0], 1'b0};
			acc = {rem_prev[RW-2:0], 1'b0} + (mb_prev[W-1] ? RW'(a_prev) : '0);
			if (acc >= c2) begin
				nrem = acc - c2;
				dig  = 2'd2;
			end else if (acc >= c1) begin
				nrem = acc - c1;
				dig  = 2'd1;
			end else begin
				nrem = acc;
				dig  = 2'd0;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i] <= nrem;
				quo_s[i] <= {quo_prev[W-2:0], 1'b0} + W'(dig);
				mb_s[i]  <= {mb_prev[W-2:0], 1'b0};
				a_s[i]   <= a_prev;
				c_s[i]   <= c_prev;
				p_s[i]   <= p_prev;
				neg_s[i] <= neg_prev;
			end
		end
	end

	assign pt = neg_s[W] ? p_s[W] - $signed(quo_s[W]) : p_s[W] + $signed(quo_s[W]);
endmodule
`default_nettype wire

>>> verif/triangle_plane_intersection_tb.sv
// Self-checking testbench for the triangle / plane crossing block.
`timescale 1ns / 1ps
module triangle_plane_intersection_tb;

	localparam int CW          = tpi_pkg::COORD_WIDTH_DEF;
	localparam int LATENCY     = CW + 10;
	localparam int IDLE_LIMIT  = 4000;
	localparam int RANDOM_ITEMS = 62;

	typedef struct {
		logic [8:0][CW-1:0] coord;
		logic [1:0]         prior;
	} triangle_t;

	typedef struct {
		logic [31:0] point_x;
		logic [31:0] point_y;
		logic [47:0] projection;
		logic        last;
	} crossing_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [tpi_pkg::APB_ADDR_W-1:0] paddr = '0;
	logic [tpi_pkg::APB_DATA_W-1:0] pwdata = '0;
	logic [tpi_pkg::APB_DATA_W-1:0] prdata;
	logic pready;

	tpi_tri_if #(.COORD_WIDTH(CW)) tri_ch ();
	tpi_pt_if pt_ch ();

	triangle_plane_intersection #(.COORD_WIDTH(CW)) dut (
		.clk(clk), .arst_n(arst_n), .triangle(tri_ch.sink), .crossing(pt_ch.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always #1 clk = ~clk;

	// Register shadows used by the predictor.
	logic signed [127:0] normal [3];
	logic signed [127:0] line_dir [3];
	logic signed [127:0] offset;
	logic [30:0] min_den;

	triangle_t pending_triangles [$];
	crossing_t expected_crossings [$];
	int unsigned mismatches = 0;
	int unsigned idle_cycles = 0;
	bit burst_mode = 1'b0;

	initial begin
		tri_ch.valid = 1'b0;
		tri_ch.ax = '0; tri_ch.ay = '0; tri_ch.az = '0;
		tri_ch.bx = '0; tri_ch.by_coord = '0; tri_ch.bz = '0;
		tri_ch.cx = '0; tri_ch.cy = '0; tri_ch.cz = '0;
		tri_ch.prior_count = '0;
		pt_ch.ready = 1'b0;
	end

	function automatic logic signed [127:0] sext_coord(logic [CW-1:0] v);
		return 128'($signed(v));
	endfunction

	function automatic logic signed [127:0] abs128(logic signed [127:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic signed [127:0] plane_distance(logic signed [127:0] v [3]);
		logic signed [127:0] s;
		s = v[0] * normal[0] + v[1] * normal[1] + v[2] * normal[2];
		return (s >>> 16) - offset;
	endfunction

	// Interpolates the crossing on edge p->q, returns 0 when the edge is skipped.
	function automatic bit edge_crossing(input logic signed [127:0] p [3],
			input logic signed [127:0] q [3], input logic signed [127:0] ep,
			input logic signed [127:0] eq, output crossing_t r);
		logic signed [127:0] adv, aep, d, prod, quo, s;
		logic signed [127:0] thr;
		logic signed [127:0] pt [3];
		logic [63:0] ptw;
		r = '{default: '0};
		if (!(ep == 0 || eq == 0 || ep[127] != eq[127]))
			return 1'b0;
		adv = abs128(eq - ep);
		thr = 128'({min_den, 16'b0});
		if (thr >= adv)
			return 1'b0;
		aep = abs128(ep);
		for (int k = 0; k < 3; k++) begin
			d = q[k] - p[k];
			prod = aep * abs128(d);
			quo = prod / adv;
			if (d < 0)
				ptw = p[k][63:0] - quo[63:0];
			else
				ptw = p[k][63:0] + quo[63:0];
			pt[k] = 128'($signed(ptw));
		end
		s = pt[0] * line_dir[0] + pt[1] * line_dir[1] + pt[2] * line_dir[2];
		s = s >>> 16;
		r.point_x = pt[0][31:0];
		r.point_y = pt[1][31:0];
		r.projection = s[47:0];
		return 1'b1;
	endfunction

	task automatic predict_crossings(input triangle_t t);
		logic signed [127:0] va [3], vb [3], vc [3];
		logic signed [127:0] ea, eb, ec;
		crossing_t found [$];
		crossing_t r;
		int running;
		for (int k = 0; k < 3; k++) begin
			va[k] = sext_coord(t.coord[k]);
			vb[k] = sext_coord(t.coord[3 + k]);
			vc[k] = sext_coord(t.coord[6 + k]);
		end
		ea = plane_distance(va);
		eb = plane_distance(vb);
		ec = plane_distance(vc);
		if (edge_crossing(va, vb, ea, eb, r)) found.insert(found.size(), r);
		if (edge_crossing(vb, vc, eb, ec, r)) found.insert(found.size(), r);
		running = int'(t.prior) + found.size();
		if (running == 1 || running == 3)
			if (edge_crossing(vc, va, ec, ea, r)) found.insert(found.size(), r);
		if (found.size() > 0)
			found[found.size() - 1].last = 1'b1;
		foreach (found[i]) expected_crossings.insert(expected_crossings.size(), found[i]);
	endtask

	function automatic int draw_wait();
		return burst_mode ? 0 : $urandom_range(0, 16);
	endfunction

	// Triangle driver.
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		triangle_t t;
		if (!arst_n) begin
			tri_ch.valid <= 1'b0;
		end else begin
			if (tri_ch.valid && tri_ch.ready)
				predict_crossings('{coord: {tri_ch.cz, tri_ch.cy, tri_ch.cx, tri_ch.bz,
					tri_ch.by_coord, tri_ch.bx, tri_ch.az, tri_ch.ay, tri_ch.ax},
					prior: tri_ch.prior_count});
			if (!tri_ch.valid || tri_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					tri_ch.valid <= 1'b0;
				end else if (pending_triangles.size() > 0) begin
					t = pending_triangles.pop_front();
					tri_ch.ax <= t.coord[0]; tri_ch.ay <= t.coord[1]; tri_ch.az <= t.coord[2];
					tri_ch.bx <= t.coord[3]; tri_ch.by_coord <= t.coord[4];
					tri_ch.bz <= t.coord[5];
					tri_ch.cx <= t.coord[6]; tri_ch.cy <= t.coord[7]; tri_ch.cz <= t.coord[8];
					tri_ch.prior_count <= t.prior;
					tri_ch.valid <= 1'b1;
					send_gap <= draw_wait();
				end else begin
					tri_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Crossing monitor and checker.
	int stall = 0;
	always @(posedge clk or negedge arst_n) begin
		crossing_t e;
		int w;
		if (!arst_n) begin
			pt_ch.ready <= 1'b0;
		end else if (pt_ch.valid && pt_ch.ready) begin
			if (expected_crossings.size() == 0) begin
				$error("unexpected crossing transaction x=%h y=%h", pt_ch.point_x,
					pt_ch.point_y);
				mismatches++;
			end else begin
				e = expected_crossings.pop_front();
				if (pt_ch.point_x !== e.point_x) begin
					$error("point_x expected %h actual %h", e.point_x, pt_ch.point_x);
					mismatches++;
				end
				if (pt_ch.point_y !== e.point_y) begin
					$error("point_y expected %h actual %h", e.point_y, pt_ch.point_y);
					mismatches++;
				end
				if (pt_ch.projection !== e.projection) begin
					$error("projection expected %h actual %h", e.projection,
						pt_ch.projection);
					mismatches++;
				end
				if (pt_ch.last !== e.last) begin
					$error("last expected %b actual %b", e.last, pt_ch.last);
					mismatches++;
				end
			end
			w = draw_wait();
			stall <= w;
			pt_ch.ready <= (w == 0);
		end else if (stall > 0) begin
			stall <= stall - 1;
			pt_ch.ready <= (stall == 1);
		end else begin
			pt_ch.ready <= 1'b1;
		end
	end

	// Watchdog on cycles without any transaction.
	always @(posedge clk) begin
		if ((tri_ch.valid && tri_ch.ready) || (pt_ch.valid && pt_ch.ready) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input logic [tpi_pkg::REG_IDX_W-1:0] idx,
			input logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= tpi_pkg::APB_ADDR_W'({idx, 3'b000}); pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			tpi_pkg::REG_NORMAL_X: normal[0] = 128'($signed(value[31:0]));
			tpi_pkg::REG_NORMAL_Y: normal[1] = 128'($signed(value[31:0]));
			tpi_pkg::REG_NORMAL_Z: normal[2] = 128'($signed(value[31:0]));
			tpi_pkg::REG_OFFSET:   offset = 128'($signed(value[47:0]));
			tpi_pkg::REG_LINE_X:   line_dir[0] = 128'($signed(value[31:0]));
			tpi_pkg::REG_LINE_Y:   line_dir[1] = 128'($signed(value[31:0]));
			tpi_pkg::REG_LINE_Z:   line_dir[2] = 128'($signed(value[31:0]));
			tpi_pkg::REG_MIN_DEN:  min_den = value[30:0];
			default: ;
		endcase
	endtask

	task automatic wait_idle();
		while (pending_triangles.size() > 0 || tri_ch.valid || expected_crossings.size() > 0)
			@(posedge clk);
		// Triangles with no crossing may still be in the pipeline.
		repeat (LATENCY + 20) @(posedge clk);
	endtask

	task automatic configure(input logic [31:0] nx, ny, nz, input logic [47:0] off,
			input logic [31:0] lx, ly, lz, input logic [30:0] md);
		wait_idle();
		write_reg(tpi_pkg::REG_NORMAL_X, 64'(nx));
		write_reg(tpi_pkg::REG_NORMAL_Y, 64'(ny));
		write_reg(tpi_pkg::REG_NORMAL_Z, 64'(nz));
		write_reg(tpi_pkg::REG_OFFSET, 64'(off));
		write_reg(tpi_pkg::REG_LINE_X, 64'(lx));
		write_reg(tpi_pkg::REG_LINE_Y, 64'(ly));
		write_reg(tpi_pkg::REG_LINE_Z, 64'(lz));
		write_reg(tpi_pkg::REG_MIN_DEN, 64'(md));
	endtask

	function automatic logic [CW-1:0] random_coord();
		case ($urandom_range(0, 3))
			0: return $urandom();
			1: return CW'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
			2: return ($urandom_range(0, 1) == 1) ? {1'b0, {(CW-1){1'b1}}} : {1'b1, {(CW-1){1'b0}}};
			default: return CW'($signed($urandom_range(0, 64)) - 32) << 16;
		endcase
	endfunction

	task automatic add_triangle(input logic [CW-1:0] a0, a1, a2, b0, b1, b2, c0, c1, c2,
			input logic [1:0] prior);
		triangle_t t;
		t.coord = {c2, c1, c0, b2, b1, b0, a2, a1, a0};
		t.prior = prior;
		pending_triangles.insert(pending_triangles.size(), t);
	endtask

	task automatic add_random(input int count);
		triangle_t t;
		for (int i = 0; i < count; i++) begin
			if (i % 20 == 0) burst_mode = ($urandom_range(0, 2) == 0);
			for (int k = 0; k < 9; k++) t.coord[k] = random_coord();
			t.prior = 2'($urandom_range(0, 3));
			pending_triangles.insert(pending_triangles.size(), t);
		end
	endtask

	localparam logic [CW-1:0] ONE = 32'h0001_0000;
	localparam logic [CW-1:0] CMAX = 32'h7fff_ffff;
	localparam logic [CW-1:0] CMIN = 32'h8000_0000;

	initial begin
		normal = '{default: '0};
		line_dir = '{default: '0};
		offset = '0;
		min_den = tpi_pkg::MIN_DEN_RESET;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: the plane normal is zero, so every distance is zero and
		// every edge has zero change; nothing is emitted.
		add_triangle(ONE, ONE, ONE, -ONE, ONE, -ONE, 0, 0, ONE, 2'd1);

		// Plane z = 0, projection on x.
		configure('0, '0, ONE, '0, ONE, '0, '0, 31'd0);
		add_triangle(0, 0, -ONE, ONE, 0, ONE, 0, ONE, ONE, 2'd0);
		add_triangle(0, 0, -ONE, ONE, 0, ONE, 0, ONE, ONE, 2'd1);
		add_triangle(0, 0, -ONE, ONE, ONE, ONE, ONE, 0, -ONE, 2'd2);
		add_triangle(0, 0, -ONE, ONE, ONE, ONE, ONE, 0, -ONE, 2'd3);
		// A vertex on the plane.
		add_triangle(ONE, ONE, 0, 0, 0, ONE, ONE, 0, -ONE, 2'd1);
		// Flat triangle lying in the plane: zero change on every edge.
		add_triangle(ONE, 0, 0, 0, ONE, 0, CMAX, CMIN, 0, 2'd3);
		// Extreme coordinates.
		add_triangle(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 2'd1);
		add_triangle(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, CMIN, CMIN, CMIN, 2'd3);
		add_triangle(CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, CMIN, 2'd0);
		add_triangle(CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, CMAX, 2'd2);
		add_triangle(0, 0, 0, 0, 0, 0, 0, 0, 0, 2'd1);
		add_random(RANDOM_ITEMS);

		// Extreme normal and offset, large line direction, wide projections.
		configure(CMIN, CMAX, CMIN, 48'h8000_0000_0000, CMAX, CMIN, CMAX, 31'd0);
		add_triangle(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN, CMAX, CMIN, CMAX, 2'd1);
		add_triangle(CMIN, CMAX, CMIN, CMAX, CMIN, CMAX, 0, 0, 0, 2'd3);
		add_random(RANDOM_ITEMS);

		configure(CMAX, CMIN, CMAX, 48'h7fff_ffff_ffff, CMIN, CMAX, CMIN, 31'd1);
		add_random(RANDOM_ITEMS / 2);

		// Largest threshold: practically every edge is skipped.
		configure(ONE, ONE, ONE, '0, ONE, ONE, ONE, 31'h7fff_ffff);
		add_triangle(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX, 0, 0, 0, 2'd1);
		add_random(RANDOM_ITEMS / 2);

		// Random plane through modest coordinates.
		configure($urandom_range(0, 32'h0002_0000) - 32'h0001_0000,
			$urandom_range(0, 32'h0002_0000) - 32'h0001_0000, ONE + $urandom_range(0, 255),
			48'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000),
			$urandom(), $urandom(), $urandom(), 31'($urandom_range(0, 32)));
		add_random(RANDOM_ITEMS);

		configure($urandom(), $urandom(), $urandom(), 48'({$urandom(), $urandom()} >> 16),
			$urandom(), $urandom(), $urandom(), 31'($urandom_range(0, 1000)));
		add_random(RANDOM_ITEMS);

		wait_idle();
		if (mismatches == 0 && expected_crossings.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

>>> sim.f
src/tpi_pkg.sv
src/tpi_tri_if.sv
src/tpi_pt_if.sv
src/tpi_smul.sv
src/tpi_div_lane.sv
src/triangle_plane_intersection.sv
verif/triangle_plane_intersection_tb.sv
